// File: rtl/rvid_pkg.sv
// Shared types and decode constants for the RV32IMA instruction decoder.
// Opcode, funct and class codes plus the funct3-indexed class tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rvid_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned CLS_W   = 7;
	localparam int unsigned OTDATA_W = 8;

	typedef enum logic [CLS_W-1:0] {
		CLS_LUI, CLS_AUIPC, CLS_JAL, CLS_JALR,
		CLS_LB, CLS_LH, CLS_LW, CLS_LBU, CLS_LHU,
		CLS_ADDI, CLS_SLTI, CLS_SLTIU, CLS_XORI, CLS_ORI, CLS_ANDI, CLS_SLLI,
		CLS_SRLI, CLS_SRAI,
		CLS_ADD, CLS_SUB, CLS_MUL, CLS_SLL, CLS_MULH, CLS_SLT, CLS_MULHSU, CLS_SLTU,
		CLS_MULHU, CLS_XOR, CLS_DIV, CLS_SRL, CLS_SRA, CLS_DIVU, CLS_OR, CLS_REM,
		CLS_AND, CLS_REMUNS,
		CLS_BEQ, CLS_BNE, CLS_BLT, CLS_BGE, CLS_BLTU, CLS_BGEU,
		CLS_SB, CLS_SH, CLS_SW,
		CLS_FENCE, CLS_FENCE_I,
		CLS_ECALL, CLS_EBREAK, CLS_MRET, CLS_SRET, CLS_URET,
		CLS_CSRRW, CLS_CSRRS, CLS_CSRRC, CLS_CSRRWI, CLS_CSRRSI, CLS_CSRRCI,
		CLS_AMOSWAP_W, CLS_AMOADD_W, CLS_AMOXOR_W, CLS_AMOAND_W, CLS_AMOOR_W,
		CLS_AMOMIN_W, CLS_AMOMAX_W, CLS_AMOMINU_W, CLS_AMOMAXU_W,
		CLS_ILLEGAL
	} cls_e;

	typedef struct packed {
		logic illegal;
		cls_e cls;
	} dec_t;

	// opcodes
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_REG    = 7'b0110011;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_FENCE  = 7'h0F;
	localparam logic [6:0] OP_SYSTEM = 7'h73;
	localparam logic [6:0] OP_AMO    = 7'h2F;

	localparam logic [6:0] F7_BASE = 7'b0000000;
	localparam logic [6:0] F7_ALT  = 7'b0100000;
	localparam logic [6:0] F7_MULDIV = 7'b0000001;

	localparam logic [2:0] F3_SR     = 3'd5;
	localparam logic [2:0] F3_FENCE  = 3'd0;
	localparam logic [2:0] F3_FENCEI = 3'd1;
	localparam logic [2:0] F3_AMO_W  = 3'd2;

	localparam logic [4:0] F5_AMOSWAP = 5'h01;
	localparam logic [4:0] F5_AMOADD  = 5'h00;
	localparam logic [4:0] F5_AMOXOR  = 5'h04;
	localparam logic [4:0] F5_AMOAND  = 5'h0C;
	localparam logic [4:0] F5_AMOOR   = 5'h08;
	localparam logic [4:0] F5_AMOMIN  = 5'h10;
	localparam logic [4:0] F5_AMOMAX  = 5'h14;
	localparam logic [4:0] F5_AMOMINU = 5'h18;
	localparam logic [4:0] F5_AMOMAXU = 5'h1C;

	// exact system words
	localparam logic [WORD_W-1:0] W_ECALL  = 32'h0000_0073;
	localparam logic [WORD_W-1:0] W_EBREAK = 32'h0010_0073;
	localparam logic [WORD_W-1:0] W_MRET   = 32'b00110000001000000000000001110011;
	localparam logic [WORD_W-1:0] W_SRET   = 32'h1020_0073;
	localparam logic [WORD_W-1:0] W_URET   = 32'h0020_0073;

	// class tables indexed by funct3
	localparam cls_e LOAD_MAP [8] = '{CLS_LB, CLS_LH, CLS_LW, CLS_ILLEGAL,
		CLS_LBU, CLS_LHU, CLS_ILLEGAL, CLS_ILLEGAL};
	localparam cls_e OPIMM_MAP [8] = '{CLS_ADDI, CLS_SLLI, CLS_SLTI, CLS_SLTIU,
		CLS_XORI, CLS_ILLEGAL, CLS_ORI, CLS_ANDI};
	localparam cls_e BRANCH_MAP [8] = '{CLS_BEQ, CLS_BNE, CLS_ILLEGAL, CLS_ILLEGAL,
		CLS_BLT, CLS_BGE, CLS_BLTU, CLS_BGEU};
	localparam cls_e STORE_MAP [8] = '{CLS_SB, CLS_SH, CLS_SW, CLS_ILLEGAL,
		CLS_ILLEGAL, CLS_ILLEGAL, CLS_ILLEGAL, CLS_ILLEGAL};
	localparam cls_e CSR_MAP [8] = '{CLS_ILLEGAL, CLS_CSRRW, CLS_CSRRS, CLS_CSRRC,
		CLS_ILLEGAL, CLS_CSRRWI, CLS_CSRRSI, CLS_CSRRCI};
	localparam cls_e REG_BASE_MAP [8] = '{CLS_ADD, CLS_SLL, CLS_SLT, CLS_SLTU,
		CLS_XOR, CLS_SRL, CLS_OR, CLS_AND};
	localparam cls_e REG_ALT_MAP [8] = '{CLS_SUB, CLS_ILLEGAL, CLS_ILLEGAL, CLS_ILLEGAL,
		CLS_ILLEGAL, CLS_SRA, CLS_ILLEGAL, CLS_ILLEGAL};
	localparam cls_e REG_MUL_MAP [8] = '{CLS_MUL, CLS_MULH, CLS_MULHSU, CLS_MULHU,
		CLS_DIV, CLS_DIVU, CLS_REM, CLS_REMUNS};

endpackage

`default_nettype wire

// File: rtl/rv32ima_instruction_decoder.sv
// An input transfer reaches m_axis_tvalid through the input register and then the result register.
// Throughput: one instruction word per cycle; both stages advance whenever the next
// stage is empty or drains in the same cycle. A held result stalls intake only once
// the input stage is also full.
// Reset: arst_n clears both stage valid flags asynchronously; the data registers are not reset.
// Top level of the RV32IMA instruction decoder: input stage, classifier, result stage.
// Depends on rvid_pkg and rvid_decode.
`timescale 1ns / 1ps
`default_nettype none

module rv32ima_instruction_decoder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [rvid_pkg::WORD_W-1:0]     s_axis_tdata,  // [31:0] instruction_word
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [rvid_pkg::OTDATA_W-1:0]        m_axis_tdata,  // [6:0] instruction_class, [7] zero
	output logic                                 m_axis_tuser   // [0] illegal
);
	import rvid_pkg::*;

	logic              v_s1;
	logic [WORD_W-1:0] word_s1;
	logic              v_s2;
	dec_t              dec_s2;
	dec_t              dec;
	logic              rdy_s1;
	logic              rdy_s2;

	assign rdy_s2        = !v_s2 || m_axis_tready;
	assign rdy_s1        = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_axis_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && rdy_s1) word_s1 <= s_axis_tdata;
		if (v_s1 && rdy_s2)          dec_s2  <= dec;
	end

	rvid_decode u_decode (
		.word (word_s1),
		.dec  (dec)
	);

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {{(OTDATA_W-CLS_W){1'b0}}, dec_s2.cls};
	assign m_axis_tuser  = dec_s2.illegal;

endmodule

`default_nettype wire

// File: rtl/rvid_decode.sv
// Combinational instruction classifier between the input and result registers.
// Depends on rvid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvid_decode (
	input  wire logic [rvid_pkg::WORD_W-1:0] word,
	output rvid_pkg::dec_t                   dec
);
	import rvid_pkg::*;

	logic [6:0] op;
	logic [2:0] f3;
	logic [6:0] f7;
	logic [4:0] f5;
	cls_e       cls;

	assign op = word[6:0];
	assign f3 = word[14:12];
	assign f7 = word[31:25];
	assign f5 = word[31:27];

	always_comb begin
		cls = CLS_ILLEGAL;
		unique case (op)
			OP_LUI:    cls = CLS_LUI;
			OP_AUIPC:  cls = CLS_AUIPC;
			OP_JAL:    cls = CLS_JAL;
			OP_JALR:   cls = CLS_JALR;
			OP_LOAD:   cls = LOAD_MAP[f3];
			OP_IMM: begin
				// slli ignores funct7; only the right shifts check it
				if (f3 == F3_SR) begin
					if (f7 == F7_BASE)     cls = CLS_SRLI;
					else if (f7 == F7_ALT) cls = CLS_SRAI;
					else                   cls = CLS_ILLEGAL;
				end else begin
					cls = OPIMM_MAP[f3];
				end
			end
			OP_REG: begin
				if (f7 == F7_BASE)        cls = REG_BASE_MAP[f3];
				else if (f7 == F7_ALT)    cls = REG_ALT_MAP[f3];
				else if (f7 == F7_MULDIV) cls = REG_MUL_MAP[f3];
				else                      cls = CLS_ILLEGAL;
			end
			OP_BRANCH: cls = BRANCH_MAP[f3];
			OP_STORE:  cls = STORE_MAP[f3];
			OP_FENCE: begin
				if (f3 == F3_FENCE)       cls = CLS_FENCE;
				else if (f3 == F3_FENCEI) cls = CLS_FENCE_I;
				else                      cls = CLS_ILLEGAL;
			end
			OP_SYSTEM: begin
				priority if (word == W_ECALL)  cls = CLS_ECALL;
				else if (word == W_EBREAK)     cls = CLS_EBREAK;
				else if (word == W_MRET)       cls = CLS_MRET;
				else if (word == W_SRET)       cls = CLS_SRET;
				else if (word == W_URET)       cls = CLS_URET;
				else                           cls = CSR_MAP[f3];
			end
			OP_AMO: begin
				// aq/rl bits are don't-care
				if (f3 != F3_AMO_W) begin
					cls = CLS_ILLEGAL;
				end else begin
					unique case (f5)
						F5_AMOSWAP: cls = CLS_AMOSWAP_W;
						F5_AMOADD:  cls = CLS_AMOADD_W;
						F5_AMOXOR:  cls = CLS_AMOXOR_W;
						F5_AMOAND:  cls = CLS_AMOAND_W;
						F5_AMOOR:   cls = CLS_AMOOR_W;
						F5_AMOMIN:  cls = CLS_AMOMIN_W;
						F5_AMOMAX:  cls = CLS_AMOMAX_W;
						F5_AMOMINU: cls = CLS_AMOMINU_W;
						F5_AMOMAXU: cls = CLS_AMOMAXU_W;
						default:    cls = CLS_ILLEGAL;
					endcase
				end
			end
			default:   cls = CLS_ILLEGAL;
		endcase
	end

	assign dec.cls     = cls;
	assign dec.illegal = (cls == CLS_ILLEGAL);

endmodule

`default_nettype wire

// File: rtl/rvid_checker.sv
// Port-level checker for the RV32IMA instruction decoder, bound to the top level.
// Depends on rvid_pkg and rv32ima_instruction_decoder.
`timescale 1ns / 1ps
`default_nettype none

module rvid_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	input  wire logic                            s_axis_tready,
	input  wire logic [rvid_pkg::WORD_W-1:0]     s_axis_tdata,
	input  wire logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	input  wire logic [rvid_pkg::OTDATA_W-1:0]   m_axis_tdata,
	input  wire logic                            m_axis_tuser
);
	import rvid_pkg::*;

	logic cls_is_illegal;
	logic pad_zero;
	logic in_xfer;

	assign cls_is_illegal = (m_axis_tdata[CLS_W-1:0] == CLS_ILLEGAL);
	assign pad_zero       = (m_axis_tdata[OTDATA_W-1:CLS_W] == '0);
	assign in_xfer        = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0 || 1'b1);

	// illegal flag agrees with the class code and the code stays in range
	a_flag_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == cls_is_illegal) && pad_zero
			&& (m_axis_tdata[CLS_W-1:0] <= CLS_ILLEGAL))
		else $error("illegal flag or class code inconsistent");

	// empty result stage never backpressures intake
	a_no_false_stall: assert property (@(posedge clk)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("intake stalled with no result pending");

	// nothing comes out of reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	// a transfer into an idle block shows up after the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !m_axis_tvalid |=> ##1 m_axis_tvalid)
		else $error("result missing after transfer");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind rv32ima_instruction_decoder rvid_checker u_rvid_checker (.*);

`default_nettype wire
